>>> hw/rtl/bsa_pkg.sv
// shared constants, types and helpers for the safety-checked resource allocator
// no dependencies; used by bsa_dpath, bsa_ctrl and the top level
`default_nettype none

package bsa_pkg;

    localparam int CUSTOMERS      = 5;
    localparam int RESOURCES      = 4;
    localparam int AMOUNT_BITS    = 8;

    localparam int CUST_BITS      = 3;
    localparam int CUST_IDX_BITS  = $clog2(CUSTOMERS);
    localparam int COUNT_BITS     = $clog2(CUSTOMERS + 1);
    localparam int WORK_BITS      = AMOUNT_BITS + $clog2(CUSTOMERS + 1);
    localparam int ORDER_IDX_BITS = 3;
    localparam int ORDER_BITS     = ORDER_IDX_BITS * CUSTOMERS;
    localparam int STATUS_BITS    = 3;

    localparam int CFG_BITS       = 32;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_INIT       = 0;
    localparam int CFG_MAX0       = 1;

    typedef logic [AMOUNT_BITS-1:0] t_amount;
    typedef logic [WORK_BITS-1:0]   t_work;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_GRANTED      = 3'd0,
        ST_EXCEEDS_NEED = 3'd1,
        ST_NO_FREE      = 3'd2,
        ST_UNSAFE       = 3'd3,
        ST_RELEASED     = 3'd4,
        ST_RELEASE_BIG  = 3'd5
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic alloc_add;
        logic alloc_sub;
        logic scan_init;
        logic scan_step;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic                  is_release;
        logic                  cust_ok;
        logic                  exceeds_need;
        logic                  exceeds_free;
        logic                  exceeds_alloc;
        logic                  scan_full;
        logic                  scan_dead;
        logic [ORDER_BITS-1:0] order;
    } t_sts;

    // a minus b, clamped at zero
    function automatic t_amount sat_sub(input t_work a, input t_work b);
        t_work diff;
        diff = a - b;
        return (a > b) ? t_amount'(diff) : '0;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/bankers_safety_allocator.sv
// top level of the deadlock-avoiding allocator: controller plus datapath
// depends on bsa_pkg, bsa_ctrl and bsa_dpath
`default_nettype none

// usage
//   item channel: drive i_req_type, i_customer and i_amount_0..3 with i_start;
//   the beat is taken at a rising edge with i_start high and o_busy low.
//   o_busy rises the cycle after and stays high until the result shows.
//   result: o_done is high for exactly one cycle with o_status and o_safe_order;
//   the receiver has no way to hold it off, so it must sample it then.
//   o_safe_order carries the finishing order (3 bits per customer, first
//   lowest) on a grant and zero for any other status.
//   configuration: i_cfg_valid with i_cfg_index and i_cfg_data, o_cfg_ready
//   always high; index 0 is the total of each resource, 1..5 the maximum
//   demand of customers 0..4, higher indices are dropped. write only while idle.
// sequencing
//   release, refusals: finished in the check state, with no scan.
//   granted or unsafe request: the check, work and scan states follow in turn; the
//   scan tests one customer per cycle and restarts at customer 0 after each pick,
//   so it takes at most 25 steps. one item at a time; the next beat can be taken
//   in the cycle o_done is high.
// reset
//   synchronous, active low: allocations, totals, configuration and control registers clear to 0.

module bankers_safety_allocator (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    output logic                                     o_busy,
    input  wire logic                                i_req_type,
    input  wire logic [bsa_pkg::CUST_BITS-1:0]       i_customer,
    input  wire logic [bsa_pkg::AMOUNT_BITS-1:0]     i_amount_0,
    input  wire logic [bsa_pkg::AMOUNT_BITS-1:0]     i_amount_1,
    input  wire logic [bsa_pkg::AMOUNT_BITS-1:0]     i_amount_2,
    input  wire logic [bsa_pkg::AMOUNT_BITS-1:0]     i_amount_3,
    output logic                                     o_done,
    output logic [bsa_pkg::STATUS_BITS-1:0]          o_status,
    output logic [bsa_pkg::ORDER_BITS-1:0]           o_safe_order,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [bsa_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  wire logic [bsa_pkg::CFG_BITS-1:0]        i_cfg_data
);

    bsa_pkg::t_cmd cmd;
    bsa_pkg::t_sts sts;
    logic [bsa_pkg::RESOURCES-1:0][bsa_pkg::AMOUNT_BITS-1:0] amount;

    // resource 0 in the lowest slot
    assign amount      = {i_amount_3, i_amount_2, i_amount_1, i_amount_0};
    // register file takes a write in any cycle
    assign o_cfg_ready = 1'b1;

    bsa_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_sts        (sts),
        .o_cmd        (cmd),
        .o_busy       (o_busy),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_safe_order (o_safe_order)
    );

    bsa_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req_type  (i_req_type),
        .i_customer  (i_customer),
        .i_amount    (amount),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

`default_nettype wire

>>> hw/rtl/bsa_dpath.sv
// datapath: configuration, allocation table, running totals and safety scan
// depends on bsa_pkg
`default_nettype none

module bsa_dpath (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_cfg_we,
    input  wire logic [bsa_pkg::CFG_IDX_BITS-1:0]        i_cfg_index,
    input  wire logic [bsa_pkg::CFG_BITS-1:0]            i_cfg_data,
    input  wire logic                                    i_req_type,
    input  wire logic [bsa_pkg::CUST_BITS-1:0]           i_customer,
    input  wire logic [bsa_pkg::RESOURCES-1:0][bsa_pkg::AMOUNT_BITS-1:0] i_amount,
    input  wire bsa_pkg::t_cmd                           i_cmd,
    output bsa_pkg::t_sts                                o_sts
);

    localparam int C  = bsa_pkg::CUSTOMERS;
    localparam int R  = bsa_pkg::RESOURCES;
    localparam int AB = bsa_pkg::AMOUNT_BITS;

    logic [bsa_pkg::CFG_BITS-1:0]       r_init;
    logic [bsa_pkg::CFG_BITS-1:0]       r_max   [C];
    bsa_pkg::t_amount                   r_alloc [C][R];
    bsa_pkg::t_work                     r_total [R];

    logic                               r_kind;
    logic [bsa_pkg::CUST_BITS-1:0]      r_cust;
    bsa_pkg::t_amount                   r_amt   [R];

    bsa_pkg::t_work                     r_work  [R];
    logic [C-1:0]                       r_finished;
    logic [bsa_pkg::CUST_IDX_BITS-1:0]  r_scan_idx;
    logic [bsa_pkg::COUNT_BITS-1:0]     r_count;
    logic [bsa_pkg::ORDER_BITS-1:0]     r_order;

    logic [C-1:0]     cust_hit;
    logic [C-1:0]     scan_hit;
    bsa_pkg::t_amount cust_alloc [R];
    bsa_pkg::t_amount cust_max   [R];
    bsa_pkg::t_amount scan_alloc [R];
    bsa_pkg::t_amount scan_max   [R];
    bsa_pkg::t_amount free_amt   [R];
    logic             cust_ok;
    logic             exc_need;
    logic             exc_free;
    logic             exc_alloc;
    logic             fits;

    // customer select by one-hot match, so an out-of-range index reads zero
    always_comb begin
        for (int c = 0; c < C; c++) begin
            cust_hit[c] = (r_cust == bsa_pkg::CUST_BITS'(c));
            scan_hit[c] = (r_scan_idx == bsa_pkg::CUST_IDX_BITS'(c));
        end
        for (int r = 0; r < R; r++) begin
            cust_alloc[r] = '0;
            cust_max[r]   = '0;
            scan_alloc[r] = '0;
            scan_max[r]   = '0;
            for (int c = 0; c < C; c++) begin
                cust_alloc[r] |= cust_hit[c] ? r_alloc[c][r] : '0;
                cust_max[r]   |= cust_hit[c] ? r_max[c][r*AB +: AB] : '0;
                scan_alloc[r] |= scan_hit[c] ? r_alloc[c][r] : '0;
                scan_max[r]   |= scan_hit[c] ? r_max[c][r*AB +: AB] : '0;
            end
        end
    end

    always_comb begin
        cust_ok   = (r_cust < bsa_pkg::CUST_BITS'(C));
        exc_need  = 1'b0;
        exc_free  = 1'b0;
        exc_alloc = 1'b0;
        fits      = ~|(r_finished & scan_hit);
        for (int r = 0; r < R; r++) begin
            free_amt[r] = bsa_pkg::sat_sub(bsa_pkg::t_work'(r_init[r*AB +: AB]), r_total[r]);
            if (r_amt[r] > bsa_pkg::sat_sub(bsa_pkg::t_work'(cust_max[r]),
                                            bsa_pkg::t_work'(cust_alloc[r])))
                exc_need = 1'b1;
            if (r_amt[r] > free_amt[r])
                exc_free = 1'b1;
            if (r_amt[r] > cust_alloc[r])
                exc_alloc = 1'b1;
            if (bsa_pkg::t_work'(bsa_pkg::sat_sub(bsa_pkg::t_work'(scan_max[r]),
                                 bsa_pkg::t_work'(scan_alloc[r]))) > r_work[r])
                fits = 1'b0;
        end
    end

    assign o_sts.is_release    = r_kind;
    assign o_sts.cust_ok       = cust_ok;
    assign o_sts.exceeds_need  = exc_need;
    assign o_sts.exceeds_free  = exc_free;
    assign o_sts.exceeds_alloc = exc_alloc;
    assign o_sts.scan_full     = (r_count == bsa_pkg::COUNT_BITS'(C));
    assign o_sts.scan_dead     = (r_scan_idx == bsa_pkg::CUST_IDX_BITS'(C - 1)) && !fits;
    assign o_sts.order         = r_order;

    // configuration, allocation table and scan bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init     <= '0;
            r_finished <= '0;
            r_scan_idx <= '0;
            r_count    <= '0;
            for (int c = 0; c < C; c++) begin
                r_max[c] <= '0;
                for (int r = 0; r < R; r++)
                    r_alloc[c][r] <= '0;
            end
            for (int r = 0; r < R; r++)
                r_total[r] <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == bsa_pkg::CFG_IDX_BITS'(bsa_pkg::CFG_INIT))
                    r_init <= i_cfg_data;
                for (int c = 0; c < C; c++)
                    if (i_cfg_index == bsa_pkg::CFG_IDX_BITS'(bsa_pkg::CFG_MAX0 + c))
                        r_max[c] <= i_cfg_data;
            end
            if (i_cmd.alloc_add || i_cmd.alloc_sub) begin
                for (int r = 0; r < R; r++) begin
                    for (int c = 0; c < C; c++)
                        if (cust_hit[c])
                            r_alloc[c][r] <= i_cmd.alloc_add ? r_alloc[c][r] + r_amt[r]
                                                             : r_alloc[c][r] - r_amt[r];
                    r_total[r] <= i_cmd.alloc_add
                                  ? r_total[r] + bsa_pkg::t_work'(r_amt[r])
                                  : r_total[r] - bsa_pkg::t_work'(r_amt[r]);
                end
            end
            if (i_cmd.scan_init) begin
                r_finished <= '0;
                r_scan_idx <= '0;
                r_count    <= '0;
            end else if (i_cmd.scan_step) begin
                if (fits) begin
                    r_finished <= r_finished | scan_hit;
                    r_count    <= r_count + 1'b1;
                    r_scan_idx <= '0;
                end else begin
                    r_scan_idx <= r_scan_idx + 1'b1;
                end
            end
        end
    end

    // latched item, work vector and finishing order
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_req_type;
            r_cust <= i_customer;
            for (int r = 0; r < R; r++)
                r_amt[r] <= i_amount[r];
        end
        if (i_cmd.scan_init) begin
            r_order <= '0;
            for (int r = 0; r < R; r++)
                r_work[r] <= bsa_pkg::t_work'(free_amt[r]);
        end else if (i_cmd.scan_step && fits) begin
            for (int r = 0; r < R; r++)
                r_work[r] <= r_work[r] + bsa_pkg::t_work'(scan_alloc[r]);
            for (int k = 0; k < C; k++)
                if (r_count == bsa_pkg::COUNT_BITS'(k))
                    r_order[k*bsa_pkg::ORDER_IDX_BITS +: bsa_pkg::ORDER_IDX_BITS] <=
                        bsa_pkg::ORDER_IDX_BITS'(r_scan_idx);
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/bsa_ctrl.sv
// controller: sequences check, tentative grant, safety scan and rollback
// depends on bsa_pkg
`default_nettype none

module bsa_ctrl (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire bsa_pkg::t_sts                    i_sts,
    output bsa_pkg::t_cmd                         o_cmd,
    output logic                                  o_busy,
    output logic                                  o_done,
    output logic [bsa_pkg::STATUS_BITS-1:0]       o_status,
    output logic [bsa_pkg::ORDER_BITS-1:0]        o_safe_order
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_WORK,
        S_SCAN
    } t_state;

    t_state                          r_state;
    logic                            r_busy;
    logic                            r_done;
    bsa_pkg::t_status                r_status;
    logic [bsa_pkg::ORDER_BITS-1:0]  r_order;

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE:  o_cmd.load = i_start;
            S_CHECK: begin
                if (i_sts.is_release)
                    o_cmd.alloc_sub = i_sts.cust_ok && !i_sts.exceeds_alloc;
                else
                    o_cmd.alloc_add = i_sts.cust_ok && !i_sts.exceeds_need
                                      && !i_sts.exceeds_free;
            end
            S_WORK:  o_cmd.scan_init = 1'b1;
            S_SCAN: begin
                if (!i_sts.scan_full) begin
                    if (i_sts.scan_dead)
                        o_cmd.alloc_sub = 1'b1;   // roll the grant back
                    else
                        o_cmd.scan_step = 1'b1;
                end
            end
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= 1'b0;
            r_done   <= 1'b0;
            r_status <= bsa_pkg::ST_GRANTED;
            r_order  <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_busy  <= 1'b1;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_order <= '0;
                    if (i_sts.is_release) begin
                        r_busy  <= 1'b0;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                        r_status <= (!i_sts.cust_ok || i_sts.exceeds_alloc)
                                    ? bsa_pkg::ST_RELEASE_BIG : bsa_pkg::ST_RELEASED;
                    end else if (!i_sts.cust_ok || i_sts.exceeds_need) begin
                        r_busy   <= 1'b0;
                        r_done   <= 1'b1;
                        r_state  <= S_IDLE;
                        r_status <= bsa_pkg::ST_EXCEEDS_NEED;
                    end else if (i_sts.exceeds_free) begin
                        r_busy   <= 1'b0;
                        r_done   <= 1'b1;
                        r_state  <= S_IDLE;
                        r_status <= bsa_pkg::ST_NO_FREE;
                    end else begin
                        r_state <= S_WORK;
                    end
                end
                S_WORK: r_state <= S_SCAN;
                S_SCAN: begin
                    if (i_sts.scan_full) begin
                        r_busy   <= 1'b0;
                        r_done   <= 1'b1;
                        r_state  <= S_IDLE;
                        r_status <= bsa_pkg::ST_GRANTED;
                        r_order  <= i_sts.order;
                    end else if (i_sts.scan_dead) begin
                        r_busy   <= 1'b0;
                        r_done   <= 1'b1;
                        r_state  <= S_IDLE;
                        r_status <= bsa_pkg::ST_UNSAFE;
                        r_order  <= '0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy       = r_busy;
    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_safe_order = r_order;

endmodule

`default_nettype wire

>>> hw/rtl/bsa_chk.sv
// port-level checker for the allocator, bound to the top level
// depends on bsa_pkg and bankers_safety_allocator
`default_nettype none

module bsa_chk (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_start,
    input wire logic                             o_busy,
    input wire logic                             o_done,
    input wire logic [bsa_pkg::STATUS_BITS-1:0]  o_status,
    input wire logic [bsa_pkg::ORDER_BITS-1:0]   o_safe_order
);

    // reset leaves the block idle with no result pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_busy && !o_done))
        else $error("busy or done after reset");

    // an accepted beat makes the block busy next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted beat without busy");

    // a result ends the busy period and never repeats next cycle
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (!o_busy ##1 !o_done))
        else $error("result strobe while busy or repeated");

    // order only on a grant
    a_order_on_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != bsa_pkg::ST_GRANTED)) |-> (o_safe_order == '0))
        else $error("finishing order on a refused item");

    // status code within the defined set
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status <= bsa_pkg::ST_RELEASE_BIG))
        else $error("undefined status code");

endmodule

bind bankers_safety_allocator bsa_chk u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_start      (i_start),
    .o_busy       (o_busy),
    .o_done       (o_done),
    .o_status     (o_status),
    .o_safe_order (o_safe_order)
);

`default_nettype wire
